### sv/bounded_fifo_with_watermarks_top_defines.svh
// ----------------------------------------------------------------------------
// Bounded FIFO with watermarks: assertion macros
// Shared concurrent assertion forms for the FIFO controller and datapath.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_FIFO_WITH_WATERMARKS_TOP_DEFINES_SVH
`define BOUNDED_FIFO_WITH_WATERMARKS_TOP_DEFINES_SVH

// same-cycle implication
`define BFW_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfw: assertion failed");

// next-cycle implication
`define BFW_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfw: assertion failed");

`endif

### sv/bfw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded FIFO with watermarks: package
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package bfw_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int MARK_W     = 7;
    localparam int LOW_W      = 6;
    localparam int CFG_W      = 7;
    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_MAX_ITEMS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HIGH_MARK = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_MARK  = 2'd2;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_EMPTY = 2'd1,
        STS_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic accept;
        logic div_start;
        logic div_step;
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
    } t_dp_sts;

endpackage

### sv/bfw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded FIFO with watermarks: controller
// Request handshakes, result valid, and sequencing of the remainder rebuild.
// ----------------------------------------------------------------------------
`include "bounded_fifo_with_watermarks_top_defines.svh"

module bfw_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    input  logic                            i_cfg_we,
    input  logic [bfw_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    output bfw_pkg::t_dp_cmd                o_cmd,
    input  bfw_pkg::t_dp_sts                i_sts
);

    typedef enum logic [1:0] {
        S_RUN = 2'b01,
        S_DIV = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_high_wr;

    assign w_high_wr  = i_cfg_we && (i_cfg_addr == bfw_pkg::REG_HIGH_MARK);
    assign o_in_ready = (r_state == S_RUN) && !i_cfg_we && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.accept    = i_in_valid && o_in_ready;
        o_cmd.div_start = w_high_wr;
        o_cmd.div_step  = (r_state == S_DIV);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_RUN: begin
                if (w_high_wr) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.accept) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_RUN;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `BFW_ASSERT_IMPL(a_no_accept_in_div, i_clk, i_rst_n, r_state == S_DIV, !o_in_ready)

endmodule

### sv/bfw_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded FIFO with watermarks: datapath
// Storage, pointers, counters, watermark remainder and result registers.
// ----------------------------------------------------------------------------
`include "bounded_fifo_with_watermarks_top_defines.svh"

module bfw_dp #(
    parameter int DEPTH      = bfw_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bfw_pkg::DATA_WIDTH_DEF,
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bfw_pkg::t_dp_cmd                i_cmd,
    output bfw_pkg::t_dp_sts                o_sts,
    input  logic                            i_cfg_we,
    input  logic [bfw_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [bfw_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  logic                            i_op,
    input  logic [DATA_WIDTH-1:0]           i_push_data,
    output logic [DATA_WIDTH-1:0]           o_pop_data,
    output logic [1:0]                      o_status,
    output logic                            o_high_event,
    output logic                            o_low_event,
    output logic [CNT_W-1:0]                o_fill_count,
    output logic [CNT_W-1:0]                o_peak_count
);

    localparam int MW    = bfw_pkg::MARK_W;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int IDX_W = $clog2(CNT_W);
    localparam int CMP_W = (CNT_W > MW) ? CNT_W : MW;

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    logic [MW-1:0]             r_max, r_high;
    logic [bfw_pkg::LOW_W-1:0] r_low;
    logic [PTR_W-1:0]          r_rd_ptr, r_wr_ptr;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [CNT_W-1:0]          r_mark, n_mark;
    logic [CNT_W-1:0]          r_peak, n_peak;
    logic [MW-1:0]             r_rem, n_rem;
    logic [MW-1:0]             r_div_acc;
    logic [IDX_W-1:0]          r_div_idx;
    logic [DATA_WIDTH-1:0]     r_rd_data;
    logic                      r_pop_ok;
    bfw_pkg::t_status          r_status, n_status;
    logic                      r_high_ev, n_high_ev;
    logic                      r_low_ev, n_low_ev;

    logic [CMP_W-1:0] w_count_x, w_cap_x, w_max_x, w_mark_x, w_high_x;
    logic             w_full, w_push_ok, w_pop_ok;
    logic [MW:0]      w_rem_inc, w_div_shift, w_div_sub;
    logic [MW-1:0]    w_rem_dec, w_div_next;
    logic [CMP_W-1:0] w_mark_sub;

    assign w_count_x = CMP_W'(r_count);
    assign w_max_x   = CMP_W'(r_max);
    assign w_mark_x  = CMP_W'(r_mark);
    assign w_high_x  = CMP_W'(r_high);
    assign w_cap_x   = (r_max == '0 || w_max_x > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : w_max_x;
    assign w_full    = w_count_x >= w_cap_x;
    assign w_push_ok = i_cmd.accept && (i_op == bfw_pkg::CMD_PUSH) && !w_full;
    assign w_pop_ok  = i_cmd.accept && (i_op == bfw_pkg::CMD_POP) && (r_count != '0);

    assign w_rem_inc  = {1'b0, r_rem} + (MW+1)'(1);
    assign w_rem_dec  = (r_rem == '0) ? (r_high - MW'(1)) : (r_rem - MW'(1));
    assign w_mark_sub = (w_mark_x >= w_high_x) ? (w_mark_x - w_high_x) : '0;

    // restoring remainder step: one count bit per cycle, MSB first
    assign w_div_shift = {r_div_acc, r_count[r_div_idx]};
    assign w_div_sub   = w_div_shift - {1'b0, r_high};
    assign w_div_next  = (w_div_shift >= {1'b0, r_high}) ? w_div_sub[MW-1:0]
                                                         : w_div_shift[MW-1:0];
    assign o_sts.div_last = (r_div_idx == '0);

    always_comb begin
        n_count   = r_count;
        n_mark    = r_mark;
        n_peak    = r_peak;
        n_rem     = r_rem;
        n_status  = bfw_pkg::STS_OK;
        n_high_ev = 1'b0;
        n_low_ev  = 1'b0;
        if (i_cmd.div_step) begin
            n_rem = (r_high == '0) ? '0 : w_div_next;
        end else if (i_op == bfw_pkg::CMD_PUSH) begin
            if (w_full) begin
                n_status = bfw_pkg::STS_FULL;
            end else begin
                n_count = r_count + CNT_W'(1);
                if (n_count > r_peak) begin
                    n_peak = n_count;
                end
                if (r_high != '0) begin
                    n_rem = (w_rem_inc == {1'b0, r_high}) ? '0 : w_rem_inc[MW-1:0];
                    if (w_rem_inc == {1'b0, r_high}) begin
                        n_high_ev = 1'b1;
                        n_mark    = n_count;
                    end
                end
            end
        end else begin
            if (r_count == '0) begin
                n_status = bfw_pkg::STS_EMPTY;
            end else begin
                n_count = r_count - CNT_W'(1);
                if (r_high != '0) begin
                    n_rem = w_rem_dec;
                    if (r_low != '0 && w_rem_dec == MW'(r_low) && r_mark > n_count) begin
                        n_low_ev = 1'b1;
                        n_mark   = w_mark_sub[CNT_W-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max     <= '0;
            r_high    <= '0;
            r_low     <= '0;
            r_rd_ptr  <= '0;
            r_wr_ptr  <= '0;
            r_count   <= '0;
            r_mark    <= '0;
            r_peak    <= '0;
            r_rem     <= '0;
            r_div_acc <= '0;
            r_div_idx <= '0;
            r_pop_ok  <= 1'b0;
            r_status  <= bfw_pkg::STS_OK;
            r_high_ev <= 1'b0;
            r_low_ev  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    bfw_pkg::REG_MAX_ITEMS: r_max  <= i_cfg_wdata;
                    bfw_pkg::REG_HIGH_MARK: r_high <= i_cfg_wdata;
                    bfw_pkg::REG_LOW_MARK:  r_low  <= i_cfg_wdata[bfw_pkg::LOW_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.div_start) begin
                r_div_acc <= '0;
                r_div_idx <= IDX_W'(CNT_W - 1);
            end else if (i_cmd.div_step) begin
                r_div_acc <= w_div_next;
                r_div_idx <= r_div_idx - IDX_W'(1);
            end
            if (i_cmd.div_step || i_cmd.accept) begin
                r_count <= n_count;
                r_mark  <= n_mark;
                r_peak  <= n_peak;
                r_rem   <= n_rem;
            end
            if (i_cmd.accept) begin
                r_pop_ok  <= w_pop_ok;
                r_status  <= n_status;
                r_high_ev <= n_high_ev;
                r_low_ev  <= n_low_ev;
            end
            if (w_push_ok) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (w_pop_ok) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            mem[r_wr_ptr] <= i_push_data;
        end
        if (w_pop_ok) begin
            r_rd_data <= mem[r_rd_ptr];
        end
    end

    assign o_pop_data   = r_pop_ok ? r_rd_data : '0;
    assign o_status     = r_status;
    assign o_high_event = r_high_ev;
    assign o_low_event  = r_low_ev;
    assign o_fill_count = r_count;
    assign o_peak_count = r_peak;

    `BFW_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `BFW_ASSERT_IMPL(a_peak_cover, i_clk, i_rst_n, 1'b1, r_peak >= r_count)
    `BFW_ASSERT_NEXT(a_push_count, i_clk, i_rst_n, w_push_ok, r_count == $past(r_count) + CNT_W'(1))

endmodule

### sv/bounded_fifo_with_watermarks_top.sv
`timescale 1ns / 1ps
// A request's result is registered and valid in the cycle after acceptance.
// Throughput: one push or pop per cycle; a result left waiting or any config write holds off the next request.
// A high_mark write rebuilds the watermark remainder one count bit per cycle, holding off
//   requests in the write cycle and until the rebuild is done.
// Reset (synchronous, active low) empties the queue and clears all registers but the read
//   data register; memory contents are not cleared.
// ----------------------------------------------------------------------------
// Bounded FIFO with watermarks: top level
// Push/pop queue with capacity limit, high/low watermark events and peak fill.
// ----------------------------------------------------------------------------
module bounded_fifo_with_watermarks_top #(
    parameter int DEPTH      = bfw_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = bfw_pkg::DATA_WIDTH_DEF,
    parameter int CNT_W      = $clog2(DEPTH + 1)
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_cmd,
    input  logic [DATA_WIDTH-1:0]           i_push_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [DATA_WIDTH-1:0]           o_pop_data,
    output logic [1:0]                      o_status,
    output logic                            o_high_event,
    output logic                            o_low_event,
    output logic [CNT_W-1:0]                o_fill_count,
    output logic [CNT_W-1:0]                o_peak_count,
    input  logic                            i_cfg_we,
    input  logic [bfw_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [bfw_pkg::CFG_W-1:0]       i_cfg_wdata
);

    bfw_pkg::t_dp_cmd w_cmd;
    bfw_pkg::t_dp_sts w_sts;

    bfw_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    bfw_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .CNT_W      (CNT_W)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_op         (i_cmd),
        .i_push_data  (i_push_data),
        .o_pop_data   (o_pop_data),
        .o_status     (o_status),
        .o_high_event (o_high_event),
        .o_low_event  (o_low_event),
        .o_fill_count (o_fill_count),
        .o_peak_count (o_peak_count)
    );

endmodule
